// ===== rtl/core/murmur2_stream_hash_assert.svh =====
// ----------------------------------------------------------------------------
// murmur2 stream hash assertion macros
// shared concurrent assertion forms on aclk, disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef MURMUR2_STREAM_HASH_ASSERT_SVH
`define MURMUR2_STREAM_HASH_ASSERT_SVH

// condition implies property in the same cycle
`define MM2_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// condition implies check in the next cycle
`define MM2_ASSERT_NEXT(label, cond, check, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (check)) \
        else $error(msg);

`endif

// ===== rtl/core/mm2_pkg.sv =====
// ----------------------------------------------------------------------------
// mm2_pkg
// constants, item type and multiply helper for the murmur2 stream hash
// ----------------------------------------------------------------------------
package mm2_pkg;

    localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
    localparam int          MIX_SHIFT   = 24;
    localparam int          FIN_SHIFT_A = 13;
    localparam int          FIN_SHIFT_B = 15;

    localparam int QUEUE_DEPTH_DEF = 4;

    // how a word enters the hash
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_PART,
        KIND_FULL
    } kind_t;

    // classified word handed from front to back
    typedef struct packed {
        kind_t       kind;
        logic [31:0] data;        // mixed word or masked partial word
        logic        start;       // first word of a message
        logic [31:0] init_value;  // seed xor length
        logic        last;
    } item_t;

    // low 32 bits of a product with the mix constant
    function automatic logic [31:0] mix_mul(input logic [31:0] a);
        return a * MIX_MUL;
    endfunction

endpackage

// ===== rtl/core/mm2_queue.sv =====
// ----------------------------------------------------------------------------
// mm2_queue
// small register queue of classified items between front and back
// ----------------------------------------------------------------------------
module mm2_queue #(
    parameter int DEPTH = mm2_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  mm2_pkg::item_t             push_item,
    input  logic                       pop,
    output mm2_pkg::item_t             pop_item,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    mm2_pkg::item_t slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item = slot_reg[rd_ptr_reg];
    assign empty    = (count_reg == '0);
    assign count    = count_reg;

endmodule

// ===== rtl/core/mm2_front.sv =====
// ----------------------------------------------------------------------------
// mm2_front
// accepts words, tracks message start, classifies and premixes full words
// ----------------------------------------------------------------------------
module mm2_front #(
    parameter int DEPTH = mm2_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [31:0]                seed_value,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [31:0]                data_word,
    input  logic [2:0]                 byte_count,
    input  logic                       last_word,
    input  logic [31:0]                message_length,
    input  logic [$clog2(DEPTH+1)-1:0] q_count,
    output logic                       q_push,
    output mm2_pkg::item_t             q_item
);

    localparam int CW = $clog2(DEPTH + 1);

    // stage 1: first mix multiply
    logic                  v1_reg;
    logic [31:0]           k1_reg;
    mm2_pkg::kind_t        kind1_reg;
    logic [31:0]           part1_reg;
    logic                  start1_reg;
    logic [31:0]           init1_reg;
    logic                  last1_reg;
    // stage 2: shift-xor and second multiply
    logic                  v2_reg;
    mm2_pkg::item_t        item2_reg;

    logic                  start_reg;
    logic                  accept;
    logic [CW:0]           used;
    mm2_pkg::kind_t        kind_in;
    logic [31:0]           part_in;
    logic [31:0]           k1_mix;

    // queue entries plus words still in the premix stages
    assign used     = {1'b0, q_count} + (CW+1)'(v1_reg) + (CW+1)'(v2_reg);
    assign s_tready = (used < (CW+1)'(DEPTH));
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        if (byte_count[2]) begin
            kind_in = mm2_pkg::KIND_FULL;
        end else if (byte_count[1:0] == 2'd0) begin
            kind_in = mm2_pkg::KIND_NONE;
        end else begin
            kind_in = mm2_pkg::KIND_PART;
        end
        case (byte_count[1:0])
            2'd1:    part_in = {24'd0, data_word[7:0]};
            2'd2:    part_in = {16'd0, data_word[15:0]};
            2'd3:    part_in = {8'd0, data_word[23:0]};
            default: part_in = 32'd0;
        endcase
    end

    assign k1_mix = k1_reg ^ (k1_reg >> mm2_pkg::MIX_SHIFT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= 1'b1;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
        end else begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            if (accept) begin
                start_reg <= last_word;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            k1_reg     <= mm2_pkg::mix_mul(data_word);
            kind1_reg  <= kind_in;
            part1_reg  <= part_in;
            start1_reg <= start_reg;
            init1_reg  <= seed_value ^ message_length;
            last1_reg  <= last_word;
        end
        if (v1_reg) begin
            item2_reg.kind       <= kind1_reg;
            item2_reg.data       <= (kind1_reg == mm2_pkg::KIND_FULL) ?
                                    mm2_pkg::mix_mul(k1_mix) : part1_reg;
            item2_reg.start      <= start1_reg;
            item2_reg.init_value <= init1_reg;
            item2_reg.last       <= last1_reg;
        end
    end

    assign q_push = v2_reg;
    assign q_item = item2_reg;

endmodule

// ===== rtl/core/mm2_back.sv =====
// ----------------------------------------------------------------------------
// mm2_back
// running hash update and finalization on one shared multiplier
// ----------------------------------------------------------------------------
module mm2_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_empty,
    input  mm2_pkg::item_t q_item,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [31:0]    hash_value
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MIX,
        ST_FIN
    } state_t;

    state_t         state_reg;
    logic [31:0]    prod_reg;
    mm2_pkg::kind_t kind_reg;
    logic [31:0]    k_reg;
    logic           last_reg;
    logic [31:0]    hsel_reg;
    logic [31:0]    hash_reg;
    logic [31:0]    out_reg;
    logic           out_valid_reg;

    logic [31:0]    hsel;
    logic [31:0]    mix_h;
    logic [31:0]    fin_in;
    logic [31:0]    mul_a;
    logic [31:0]    mul_p;
    logic           can_load;

    assign hsel = q_item.start ? q_item.init_value : hash_reg;

    always_comb begin
        case (kind_reg)
            mm2_pkg::KIND_FULL: mix_h = prod_reg ^ k_reg;
            mm2_pkg::KIND_PART: mix_h = prod_reg;
            default:            mix_h = hsel_reg;
        endcase
    end

    assign fin_in   = mix_h ^ (mix_h >> mm2_pkg::FIN_SHIFT_A);
    assign mul_a    = (state_reg == ST_IDLE) ?
                      ((q_item.kind == mm2_pkg::KIND_PART) ? (hsel ^ q_item.data) : hsel) :
                      fin_in;
    assign mul_p    = mm2_pkg::mix_mul(mul_a);
    assign can_load = !out_valid_reg || m_tready;
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            hash_reg      <= 32'd0;
        end else begin
            // a waiting hash leaves on ready unless a new one takes its place
            if (m_tready && (state_reg != ST_FIN)) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        prod_reg  <= mul_p;
                        kind_reg  <= q_item.kind;
                        k_reg     <= q_item.data;
                        last_reg  <= q_item.last;
                        hsel_reg  <= hsel;
                        state_reg <= ST_MIX;
                    end
                end
                ST_MIX: begin
                    hash_reg <= mix_h;
                    if (last_reg) begin
                        prod_reg  <= mul_p;
                        state_reg <= ST_FIN;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_FIN: begin
                    if (can_load) begin
                        out_reg       <= prod_reg ^ (prod_reg >> mm2_pkg::FIN_SHIFT_B);
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign hash_value = out_reg;

endmodule

// ===== rtl/core/murmur2_stream_hash.sv =====
// ----------------------------------------------------------------------------
// murmur2_stream_hash
// streaming 32-bit MurmurHash2 over little-endian words
// ----------------------------------------------------------------------------
// A message enters as 32-bit words, first byte in bits 7:0, each with a
// valid-byte count and a last mark; the total length rides on the first word
// and seeds the hash together with the seed register. One hash leaves per
// message, on the transaction after the last word. The front takes one word
// per cycle while the queue has credit, and premixes full words in a two-stage
// multiply pipeline. The back holds the running hash and one multiplier: it
// takes a word from the queue only in its idle state, so each word passes
// through the mix state, and a message's last word also through the finalize
// state, before the next is taken; the sustained rate is set by the running
// hash loop through that multiplier. Write the seed only while the block is
// idle; a new seed applies from the next message start.
module murmur2_stream_hash #(
    parameter int QUEUE_DEPTH = mm2_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // seed register write
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,    // seed_value
    // word input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,      // data_word, byte_count, message_length, zero pad
    input  logic        s_tlast,      // last_word
    // hash output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata       // hash_value
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [31:0]    seed_reg;
    logic [CW-1:0]  q_count;
    logic           q_push;
    logic           q_pop;
    logic           q_empty;
    mm2_pkg::item_t q_push_item;
    mm2_pkg::item_t q_pop_item;

    // seed register, no read-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= 32'd0;
        end else if (cfg_we) begin
            seed_reg <= cfg_wdata;
        end
    end

    // front: accept, classify, premix
    mm2_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .seed_value     (seed_reg),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .data_word      (s_tdata[31:0]),
        .byte_count     (s_tdata[34:32]),
        .last_word      (s_tlast),
        .message_length (s_tdata[66:35]),
        .q_count        (q_count),
        .q_push         (q_push),
        .q_item         (q_push_item)
    );

    // decoupling queue
    mm2_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_push_item),
        .pop       (q_pop),
        .pop_item  (q_pop_item),
        .empty     (q_empty),
        .count     (q_count)
    );

    // back: running hash and finalization
    mm2_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_item     (q_pop_item),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .hash_value (m_tdata)
    );

`include "murmur2_stream_hash_assert.svh"

    // credit scheme must keep the queue from overflowing
    `MM2_ASSERT(a_no_overflow, q_push && !q_pop |-> q_count < CW'(QUEUE_DEPTH), "queue overflow")
    // back never pops an empty queue
    `MM2_ASSERT(a_no_underflow, q_pop |-> !q_empty, "pop from empty queue")
    // queue occupancy tracks a lone push
    `MM2_ASSERT_NEXT(a_count_up, q_push && !q_pop, q_count == $past(q_count) + CW'(1), "count off")

endmodule
